// ----- rtl/rmdr_pkg.sv -----
// ----------------------------------------------------------------------------
// rmdr_pkg
// shared widths, types and command/status structs for the rational unit
// ----------------------------------------------------------------------------
package rmdr_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int DEN_W         = OPERAND_WIDTH - 1;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;  // product magnitude
  localparam int RES_NUM_W     = 2 * OPERAND_WIDTH - 1;
  localparam int RES_DEN_W     = 2 * OPERAND_WIDTH - 2;
  localparam int CNT_W         = $clog2(MAG_W + 1);

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic load;    // capture operands and form products
    logic gcd_go;  // one binary gcd step
    logic div_go;  // one restoring-division step
    logic div_ini; // start division of both magnitudes
    logic fin;     // saturate and load output register
  } cmd_t;

  typedef struct packed {
    logic zero;    // result is 0/1
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/rmdr_if.sv -----
// ----------------------------------------------------------------------------
// rmdr_in_if / rmdr_out_if
// valid/ready channels for operands and results
// ----------------------------------------------------------------------------
interface rmdr_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      opcode;
  logic signed [rmdr_pkg::OPERAND_WIDTH-1:0] a_num;
  logic        [rmdr_pkg::DEN_W-1:0]         a_den;
  logic signed [rmdr_pkg::OPERAND_WIDTH-1:0] b_num;
  logic        [rmdr_pkg::DEN_W-1:0]         b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rmdr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rmdr_pkg::RES_NUM_W-1:0] res_num;
  logic        [rmdr_pkg::RES_DEN_W-1:0] res_den;
  modport source (output valid, res_num, res_den, input ready);
  modport sink   (input valid, res_num, res_den, output ready);
endinterface

// ----- rtl/rmdr_dp.sv -----
// ----------------------------------------------------------------------------
// rmdr_dp
// datapath: products, binary gcd, bit-serial division, saturation
// ----------------------------------------------------------------------------
module rmdr_dp (
  input  logic                                      clk,
  input  rmdr_pkg::cmd_t                            cmd,
  output rmdr_pkg::sts_t                            sts,
  input  logic                                      opcode,
  input  logic signed [rmdr_pkg::OPERAND_WIDTH-1:0] a_num,
  input  logic        [rmdr_pkg::DEN_W-1:0]         a_den,
  input  logic signed [rmdr_pkg::OPERAND_WIDTH-1:0] b_num,
  input  logic        [rmdr_pkg::DEN_W-1:0]         b_den,
  output logic signed [rmdr_pkg::RES_NUM_W-1:0]     res_num,
  output logic        [rmdr_pkg::RES_DEN_W-1:0]     res_den
);
  localparam int W  = rmdr_pkg::MAG_W;
  localparam int OW = rmdr_pkg::OPERAND_WIDTH;
  localparam int BW = $clog2(W);

  rmdr_pkg::mag_t n_r, d_r, u_r, v_r, q_n_r, q_d_r, rem_n_r, rem_d_r, g_r;
  logic [rmdr_pkg::CNT_W-1:0] k_r, bit_r;
  logic neg_r, zero_r;

  // operand magnitudes, zero denominators read as one
  logic [OW-1:0] a_mag, b_mag, a_d, b_d;
  assign a_mag = a_num[OW-1] ? OW'(-a_num) : OW'(a_num);
  assign b_mag = b_num[OW-1] ? OW'(-b_num) : OW'(b_num);
  assign a_d   = (a_den == '0) ? OW'(1) : {1'b0, a_den};
  assign b_d   = (b_den == '0) ? OW'(1) : {1'b0, b_den};

  logic [OW-1:0] m1a, m1b, m2a, m2b;
  assign m1a = a_mag;
  assign m1b = opcode ? b_d : b_mag;
  assign m2a = a_d;
  assign m2b = opcode ? b_mag : b_d;

  // binary gcd step on u, v
  rmdr_pkg::mag_t diff;
  assign diff = (u_r > v_r) ? (u_r - v_r) : (v_r - u_r);

  // restoring division step, both quotients in parallel, msb first
  logic [BW-1:0] bit_idx;
  assign bit_idx = BW'(bit_r - 1'b1);

  rmdr_pkg::mag_t tn, td;
  assign tn = {rem_n_r[W-2:0], n_r[bit_idx]};
  assign td = {rem_d_r[W-2:0], d_r[bit_idx]};

  assign sts.zero     = zero_r;
  assign sts.gcd_done = (v_r == '0);
  assign sts.div_done = (bit_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= m1a * m1b;
      d_r    <= m2a * m2b;
      u_r    <= m1a * m1b;
      v_r    <= m2a * m2b;
      k_r    <= '0;
      neg_r  <= a_num[OW-1] ^ b_num[OW-1];
      zero_r <= (a_mag == '0) || (b_mag == '0);
    end else if (cmd.gcd_go) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else begin
        u_r <= (u_r < v_r) ? u_r : v_r;
        v_r <= diff >> 1;
      end
    end
    if (cmd.div_ini) begin
      g_r     <= u_r << k_r;
      rem_n_r <= '0;
      rem_d_r <= '0;
      bit_r   <= rmdr_pkg::CNT_W'(W);
    end else if (cmd.div_go) begin
      bit_r   <= bit_r - 1'b1;
      q_n_r   <= {q_n_r[W-2:0], tn >= g_r};
      q_d_r   <= {q_d_r[W-2:0], td >= g_r};
      rem_n_r <= (tn >= g_r) ? tn - g_r : tn;
      rem_d_r <= (td >= g_r) ? td - g_r : td;
    end
    if (cmd.fin) begin
      if (zero_r) begin
        res_num <= '0;
        res_den <= rmdr_pkg::RES_DEN_W'(1);
      end else begin
        if (neg_r)
          res_num <= (q_n_r > (W'(1) << (rmdr_pkg::RES_NUM_W-1)))
                     ? {1'b1, {(rmdr_pkg::RES_NUM_W-1){1'b0}}}
                     : rmdr_pkg::RES_NUM_W'(-q_n_r);
        else
          res_num <= (q_n_r > W'({(rmdr_pkg::RES_NUM_W-1){1'b1}}))
                     ? {1'b0, {(rmdr_pkg::RES_NUM_W-1){1'b1}}}
                     : rmdr_pkg::RES_NUM_W'(q_n_r);
        res_den <= (q_d_r > W'({rmdr_pkg::RES_DEN_W{1'b1}}))
                   ? {rmdr_pkg::RES_DEN_W{1'b1}} : rmdr_pkg::RES_DEN_W'(q_d_r);
      end
    end
  end
endmodule

// ----- rtl/rmdr_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmdr_ctrl
// sequencer: load, gcd loop, division loop, output register handshake
// ----------------------------------------------------------------------------
module rmdr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rmdr_pkg::cmd_t cmd,
  input  rmdr_pkg::sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DINI = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  // a new item may enter while the last result still waits
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.zero || sts.gcd_done) begin
          state_nxt = sts.zero ? S_FIN : S_DINI;
        end else begin
          cmd.gcd_go = 1'b1;
        end
      end
      S_DINI: begin
        cmd.div_ini = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIN;
        else cmd.div_go = 1'b1;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.fin   = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

// ----- rtl/rational_mul_div_reduce.sv -----
// flow: after accept, the binary gcd loop over products of at most 31 bits
//   and its exit check, division setup, a 32-step division with its exit
//   check, then the output register load; a zero result skips gcd and
//   division
// throughput: one transaction at a time; next is taken once the result is
//   registered, even if that result is still waiting on the sink
// reset: synchronous active-low rst_n clears the sequencer and output valid
// ----------------------------------------------------------------------------
// rational_mul_div_reduce
// multiply or divide two fractions and reduce the result to lowest terms
// ----------------------------------------------------------------------------
module rational_mul_div_reduce (
  input logic        clk,
  input logic        rst_n,
  rmdr_in_if.sink    in_ch,
  rmdr_out_if.source out_ch
);
  // command and status between sequencer and datapath
  rmdr_pkg::cmd_t cmd;
  rmdr_pkg::sts_t sts;

  // sequencer owns the handshakes
  rmdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath holds products, gcd registers, quotients and the result register
  rmdr_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .opcode  (in_ch.opcode),
    .a_num   (in_ch.a_num),
    .a_den   (in_ch.a_den),
    .b_num   (in_ch.b_num),
    .b_den   (in_ch.b_den),
    .res_num (out_ch.res_num),
    .res_den (out_ch.res_den)
  );
endmodule

// ----- dv/tb_rational_mul_div_reduce.sv -----
// ----------------------------------------------------------------------------
// tb_rational_mul_div_reduce
// directed and random checks of the rational multiply/divide unit: every
// operand transaction is predicted to a reduced fraction and compared with
// the results in order, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_rational_mul_div_reduce;
  import rmdr_pkg::*;

  localparam int NUM_MAX = (1 << (RES_NUM_W - 1)) - 1;
  localparam int DEN_MAX = (1 << RES_DEN_W) - 1;

  typedef enum logic {OP_MUL = 1'b0, OP_DIV = 1'b1} op_e;

  typedef struct {
    logic signed [RES_NUM_W-1:0] num;
    logic        [RES_DEN_W-1:0] den;
  } frac_t;

  logic clk;
  logic rst_n;
  int   errors;
  bit   idle_free;   // when set, neither side idles

  rmdr_in_if  in_ch ();
  rmdr_out_if out_ch ();

  rational_mul_div_reduce uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  frac_t expected_q[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  // euclid on the product magnitudes
  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduced product or quotient of two fractions
  function automatic frac_t reduce_fraction(op_e op, logic signed [OPERAND_WIDTH-1:0] an,
                                            logic [DEN_W-1:0] ad,
                                            logic signed [OPERAND_WIDTH-1:0] bn,
                                            logic [DEN_W-1:0] bd);
    longint unsigned am, bm, adv, bdv, nm, dm, g;
    bit neg;
    frac_t r;
    am  = (an < 0) ? -longint'(an) : longint'(an);
    bm  = (bn < 0) ? -longint'(bn) : longint'(bn);
    adv = (ad == 0) ? 1 : ad;   // zero denominator read as one
    bdv = (bd == 0) ? 1 : bd;
    if (am == 0 || bm == 0) begin
      r.num = '0;
      r.den = RES_DEN_W'(1);
      return r;
    end
    if (op == OP_DIV) begin
      nm = am * bdv;
      dm = adv * bm;
    end else begin
      nm = am * bm;
      dm = adv * bdv;
    end
    neg = (an < 0) != (bn < 0);
    g = gcd_of(nm, dm);
    nm = nm / g;
    dm = dm / g;
    // saturate to the output range
    if (neg && nm > NUM_MAX + 1) nm = NUM_MAX + 1;
    if (!neg && nm > NUM_MAX) nm = NUM_MAX;
    if (dm > DEN_MAX) dm = DEN_MAX;
    r.num = RES_NUM_W'(neg ? -longint'(nm) : longint'(nm));
    r.den = RES_DEN_W'(dm);
    return r;
  endfunction

  // result sink: random back-pressure, in-order compare
  initial begin
    frac_t exp_r;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result num=%0d den=%0d", $time,
                   out_ch.res_num, out_ch.res_den);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.res_num !== exp_r.num) begin
            $display("%0t res_num mismatch: expected %0d actual %0d", $time,
                     exp_r.num, out_ch.res_num);
            errors++;
          end
          if (out_ch.res_den !== exp_r.den) begin
            $display("%0t res_den mismatch: expected %0d actual %0d", $time,
                     exp_r.den, out_ch.res_den);
            errors++;
          end
        end
      end
      out_ch.ready <= idle_free || ($urandom_range(99) >= 34);
    end
  end

  // drive one operand transaction and record its expected result;
  // valid stays high after acceptance until the next idle cycle or the end
  task automatic send_operands(op_e op, logic signed [OPERAND_WIDTH-1:0] an,
                               logic [DEN_W-1:0] ad,
                               logic signed [OPERAND_WIDTH-1:0] bn,
                               logic [DEN_W-1:0] bd);
    while (!idle_free && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.a_num  <= an;
    in_ch.a_den  <= ad;
    in_ch.b_num  <= bn;
    in_ch.b_den  <= bd;
    expected_q.push_back(reduce_fraction(op, an, ad, bn, bd));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // field extremes, both operations, the listed corner cases
  task automatic test_directed();
    send_operands(OP_MUL, 16'sd1, 15'd1, 16'sd1, 15'd1);
    send_operands(OP_DIV, 16'sd1, 15'd1, 16'sd1, 15'd1);
    send_operands(OP_MUL, 16'sd32767, 15'd1, 16'sd32767, 15'd1);
    send_operands(OP_MUL, -16'sd32767, 15'd1, 16'sd32767, 15'd1);
    send_operands(OP_DIV, 16'sd1, 15'd32767, 16'sd32767, 15'd1);
    send_operands(OP_DIV, 16'sd32767, 15'd1, 16'sd1, 15'd32767);
    send_operands(OP_MUL, 16'sd5, 15'd32767, -16'sd3, 15'd32767);
    // zero denominators read as one
    send_operands(OP_MUL, 16'sd7, 15'd0, 16'sd3, 15'd0);
    send_operands(OP_DIV, -16'sd7, 15'd0, 16'sd3, 15'd0);
    // divide by a zero fraction
    send_operands(OP_DIV, 16'sd9, 15'd4, 16'sd0, 15'd5);
    send_operands(OP_DIV, -16'sd32768, 15'd3, 16'sd0, 15'd32767);
    // zero result
    send_operands(OP_MUL, 16'sd0, 15'd9, -16'sd4, 15'd2);
    send_operands(OP_MUL, 16'sd4, 15'd9, 16'sd0, 15'd2);
    send_operands(OP_DIV, 16'sd0, 15'd1, -16'sd1, 15'd1);
    // most negative numerator, and the overflowing square
    send_operands(OP_MUL, -16'sd32768, 15'd1, 16'sd1, 15'd1);
    send_operands(OP_DIV, -16'sd32768, 15'd1, -16'sd32768, 15'd32767);
    send_operands(OP_MUL, -16'sd32768, 15'd1, -16'sd32768, 15'd1);
    send_operands(OP_MUL, -16'sd32768, 15'd1, 16'sd32767, 15'd1);
    // heavy reduction
    send_operands(OP_MUL, 16'sd12, 15'd18, -16'sd27, 15'd8);
    send_operands(OP_DIV, -16'sd1024, 15'd4096, -16'sd2048, 15'd512);
  endtask

  // random operands, mostly full range with some small values for reduction
  task automatic test_random(int n);
    logic signed [OPERAND_WIDTH-1:0] an, bn;
    logic [DEN_W-1:0] ad, bd;
    for (int i = 0; i < n; i++) begin
      idle_free = (i >= n / 2) && (i < n / 2 + 150);
      if ($urandom_range(3) == 0) begin
        an = $signed(16'($urandom_range(64))) - 16'sd32;
        bn = $signed(16'($urandom_range(64))) - 16'sd32;
        ad = DEN_W'($urandom_range(64));
        bd = DEN_W'($urandom_range(64));
      end else begin
        an = OPERAND_WIDTH'($urandom);
        bn = OPERAND_WIDTH'($urandom);
        ad = DEN_W'($urandom);
        bd = DEN_W'($urandom);
      end
      send_operands(op_e'($urandom_range(1)), an, ad, bn, bd);
    end
    idle_free = 1'b0;
  endtask

  initial begin
    int guard;
    errors = 0;
    idle_free = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_MUL;
    in_ch.a_num  <= '0;
    in_ch.a_den  <= '0;
    in_ch.b_num  <= '0;
    in_ch.b_den  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1200);
    in_ch.valid <= 1'b0;
    // drain outstanding results, then allow the block to settle
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t %0d results never arrived", $time, expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
